// ===== rtl/stdec_pkg.sv =====
// ----------------------------------------------------------------------------
// stdec_pkg: shared types and constants of the scratchpad temperature decoder
// Frame length, sensor family code, CRC polynomial, status codes and the
// control structs that pass between the top level and its serial units.
// ----------------------------------------------------------------------------
package stdec_pkg;

    // Frame shape and sensor constants
    localparam int unsigned  FRAME_BYTES_N = 9;
    localparam logic [3:0]   FRAME_BYTES   = 4'(FRAME_BYTES_N);
    localparam logic [3:0]   INDEX_MAX     = 4'hF;
    localparam logic [7:0]   LEGACY_FAMILY = 8'h10;
    localparam logic [7:0]   FAMILY_RESET  = 8'h28;
    localparam logic [7:0]   CRC_POLY      = 8'h8C;
    localparam logic [15:0]  DISC_TEMP     = 16'hE480;
    localparam logic [15:0]  LEGACY_OFFSET = 16'd32;

    // Byte positions stored from the scratchpad
    localparam logic [3:0]   IDX_TEMP_LSB  = 4'd0;
    localparam logic [3:0]   IDX_TEMP_MSB  = 4'd1;
    localparam logic [3:0]   IDX_COUNT_REM = 4'd6;
    localparam logic [3:0]   IDX_COUNT_PER = 4'd7;

    // Divider widths: |cpc - cr| * 128 needs 15 bits, divisor is one byte
    localparam int unsigned  DIV_NUM_W = 15;
    localparam int unsigned  DIV_DEN_W = 8;
    localparam int unsigned  DIV_CNT_W = $clog2(DIV_NUM_W);

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_LINK = 2'd1,
        ST_ZERO = 2'd2,
        ST_CRC  = 2'd3
    } t_status;

    // Control into the CRC unit
    typedef struct packed {
        logic load;
        logic clear;
    } t_crc_ctrl;

    // Status back from a serial unit
    typedef struct packed {
        logic busy;
    } t_unit_stat;

endpackage

// ===== rtl/stdec_if.sv =====
// ----------------------------------------------------------------------------
// stdec_if: valid/ready channels of the scratchpad temperature decoder
// Input channel carries scratchpad bytes, output channel carries results.
// ----------------------------------------------------------------------------
interface stdec_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       link_fault;

    modport source (output valid, output data_byte, output last_byte,
                    output link_fault, input ready);
    modport sink   (input valid, input data_byte, input last_byte,
                    input link_fault, output ready);
endinterface

interface stdec_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] temperature;
    logic               valid_res;
    logic [1:0]         status;

    modport source (output valid, output temperature, output valid_res,
                    output status, input ready);
    modport sink   (input valid, input temperature, input valid_res,
                    input status, output ready);
endinterface

// ===== rtl/stdec_crc.sv =====
// ----------------------------------------------------------------------------
// stdec_crc: bit-serial CRC-8 (reflected polynomial 0x8C, initial 0)
// Shifts one byte in LSB first into the running CRC.
// ----------------------------------------------------------------------------
module stdec_crc (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  stdec_pkg::t_crc_ctrl  i_ctrl,
    input  logic [7:0]            i_byte,
    output stdec_pkg::t_unit_stat o_stat,
    output logic [7:0]            o_crc
);

    logic [7:0] r_crc;
    logic [7:0] r_shift;
    logic [2:0] r_cnt;
    logic       r_busy;
    logic       mix;
    logic [7:0] n_crc;

    // One LFSR step on the lowest pending data bit
    assign mix   = r_crc[0] ^ r_shift[0];
    assign n_crc = (r_crc >> 1) ^ (mix ? stdec_pkg::CRC_POLY : 8'h00);

    // Clear at frame end, load a byte, then advance one bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= 8'h00;
            r_busy <= 1'b0;
            r_cnt  <= 3'd0;
        end else if (i_ctrl.clear) begin
            r_crc  <= 8'h00;
            r_busy <= 1'b0;
            r_cnt  <= 3'd0;
        end else if (i_ctrl.load) begin
            r_shift <= i_byte;
            r_cnt   <= 3'd0;
            r_busy  <= 1'b1;
        end else if (r_busy) begin
            r_crc   <= n_crc;
            r_shift <= r_shift >> 1;
            r_cnt   <= r_cnt + 3'd1;
            if (r_cnt == 3'd7) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_crc       = r_crc;
    assign o_stat.busy = r_busy;

endmodule

// ===== rtl/stdec_div.sv =====
// ----------------------------------------------------------------------------
// stdec_div: restoring unsigned divider, one quotient bit per cycle
// Divides the 15-bit numerator magnitude by the one-byte divisor.
// ----------------------------------------------------------------------------
module stdec_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [stdec_pkg::DIV_NUM_W-1:0]     i_num,
    input  logic [stdec_pkg::DIV_DEN_W-1:0]     i_den,
    output stdec_pkg::t_unit_stat               o_stat,
    output logic [stdec_pkg::DIV_NUM_W-1:0]     o_quo
);

    localparam int unsigned NW = stdec_pkg::DIV_NUM_W;
    localparam int unsigned DW = stdec_pkg::DIV_DEN_W;
    localparam int unsigned CW = stdec_pkg::DIV_CNT_W;

    logic [NW-1:0] r_num;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_den;
    logic [DW-1:0] r_rem;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [DW:0]   rem_sh;
    logic [DW:0]   rem_sub;
    logic          ge;

    // Bring down the next numerator bit and trial-subtract
    assign rem_sh  = {r_rem, r_num[NW-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign ge      = (rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_cnt  <= '0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            r_quo <= {r_quo[NW-2:0], ge};
            r_num <= r_num << 1;
            r_cnt <= r_cnt + CW'(1);
            if (r_cnt == CW'(NW - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_quo       = r_quo;
    assign o_stat.busy = r_busy;

endmodule

// ===== rtl/scratchpad_temperature_decode.sv =====
// ----------------------------------------------------------------------------
// scratchpad_temperature_decode: 1-Wire sensor scratchpad to temperature
// Checks a 9-byte scratchpad frame (length, link, all-zero, CRC-8) and
// returns the temperature in 1/128 degree C, or -7040 with an error status.
//
//   channel   dir  handshake      payload
//   i_in      in   valid/ready    data_byte[7:0], last_byte, link_fault
//   o_out     out  valid/ready    temperature[15:0] signed, valid_res, status
//   i_cfg_*   in   write enable   family_code[7:0]
//
// Order: each byte is loaded into the bit-serial CRC and shifted through it
// before the next byte is taken. A last byte then loads the output register;
// on a good legacy-family frame with a nonzero count-per byte, the
// one-bit-per-cycle 15-bit divider and the final add come first.
// Reset: synchronous, clears frame state and output valid; family_code = 40.
// Stalls: a finished result sits in the output register while the next byte
// is taken; a second result waits until the first beat has left.
// ----------------------------------------------------------------------------
module scratchpad_temperature_decode (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    stdec_in_if.sink    i_in,
    stdec_out_if.source o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CRC,
        S_DIV,
        S_DONE
    } t_state;

    t_state                          r_state;
    logic [7:0]                      r_family;
    logic [3:0]                      r_index;
    logic                            r_any_nz;
    logic                            r_fault;
    logic                            r_last;
    logic [7:0]                      r_temp_lsb;
    logic [7:0]                      r_temp_msb;
    logic [7:0]                      r_count_rem;
    logic [7:0]                      r_count_per;
    logic                            r_neg;
    logic [15:0]                     r_temp;
    stdec_pkg::t_status              r_status;
    logic                            r_out_valid;
    logic [15:0]                     r_out_temp;
    logic                            r_out_ok;
    stdec_pkg::t_status              r_out_status;

    stdec_pkg::t_crc_ctrl            crc_ctrl;
    stdec_pkg::t_unit_stat           crc_stat;
    stdec_pkg::t_unit_stat           div_stat;
    logic [7:0]                      crc_val;
    logic                            div_start;
    logic [stdec_pkg::DIV_NUM_W-1:0] div_num;
    logic [stdec_pkg::DIV_NUM_W-1:0] div_quo;

    logic                            in_beat;
    logic                            frame_end;
    logic                            slot_free;
    stdec_pkg::t_status              chk_status;
    logic                            use_legacy;
    logic [8:0]                      diff;
    logic [7:0]                      diff_mag;
    logic [15:0]                     temp_plain;
    logic [15:0]                     temp_base;
    logic [15:0]                     q_signed;

    // Handshake
    assign i_in.ready = (r_state == S_IDLE);
    assign in_beat    = i_in.valid && i_in.ready;
    assign slot_free  = !r_out_valid || o_out.ready;
    assign frame_end  = (r_state == S_CRC) && !crc_stat.busy && r_last;

    // Frame checks in priority order
    always_comb begin
        if (r_fault || (r_index != stdec_pkg::FRAME_BYTES)) begin
            chk_status = stdec_pkg::ST_LINK;
        end else if (!r_any_nz) begin
            chk_status = stdec_pkg::ST_ZERO;
        end else if (crc_val != 8'h00) begin
            chk_status = stdec_pkg::ST_CRC;
        end else begin
            chk_status = stdec_pkg::ST_OK;
        end
    end

    assign use_legacy = (r_family == stdec_pkg::LEGACY_FAMILY) && (r_count_per != 8'h00);

    // Temperature words and the legacy fraction numerator
    assign temp_plain = {r_temp_msb[4:0], r_temp_lsb, 3'b000};
    assign temp_base  = {r_temp_msb[1:0], r_temp_lsb[7:1], 7'b0000000};
    assign diff       = {1'b0, r_count_per} - {1'b0, r_count_rem};
    assign diff_mag   = diff[8] ? 8'(-diff) : diff[7:0];
    assign div_num    = {diff_mag, 7'b0000000};
    assign q_signed   = r_neg ? 16'(-{1'b0, div_quo}) : {1'b0, div_quo};

    // Unit control
    assign crc_ctrl.load  = in_beat;
    assign crc_ctrl.clear = frame_end;
    assign div_start      = frame_end && (chk_status == stdec_pkg::ST_OK) && use_legacy;

    stdec_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (crc_ctrl),
        .i_byte  (i_in.data_byte),
        .o_stat  (crc_stat),
        .o_crc   (crc_val)
    );

    stdec_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_count_per),
        .o_stat  (div_stat),
        .o_quo   (div_quo)
    );

    // Sequencer, frame state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_family    <= stdec_pkg::FAMILY_RESET;
            r_index     <= 4'd0;
            r_any_nz    <= 1'b0;
            r_fault     <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_family <= i_cfg_wdata;
            end

            // Raise the output beat on a finished reading, drop it once taken
            if ((r_state == S_DONE) && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        unique case (r_index)
                            stdec_pkg::IDX_TEMP_LSB:  r_temp_lsb  <= i_in.data_byte;
                            stdec_pkg::IDX_TEMP_MSB:  r_temp_msb  <= i_in.data_byte;
                            stdec_pkg::IDX_COUNT_REM: r_count_rem <= i_in.data_byte;
                            stdec_pkg::IDX_COUNT_PER: r_count_per <= i_in.data_byte;
                            default: ;
                        endcase
                        if (i_in.data_byte != 8'h00) begin
                            r_any_nz <= 1'b1;
                        end
                        if (i_in.link_fault) begin
                            r_fault <= 1'b1;
                        end
                        if (r_index != stdec_pkg::INDEX_MAX) begin
                            r_index <= r_index + 4'd1;
                        end
                        r_last  <= i_in.last_byte;
                        r_state <= S_CRC;
                    end
                end
                S_CRC: begin
                    if (!crc_stat.busy) begin
                        if (!r_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            // Close the frame and pick the result path
                            r_index  <= 4'd0;
                            r_any_nz <= 1'b0;
                            r_fault  <= 1'b0;
                            r_status <= chk_status;
                            r_neg    <= diff[8];
                            if (chk_status != stdec_pkg::ST_OK) begin
                                r_temp  <= stdec_pkg::DISC_TEMP;
                                r_state <= S_DONE;
                            end else if (use_legacy) begin
                                r_state <= S_DIV;
                            end else begin
                                r_temp  <= temp_plain;
                                r_state <= S_DONE;
                            end
                        end
                    end
                end
                S_DIV: begin
                    if (!div_stat.busy) begin
                        r_temp  <= temp_base - stdec_pkg::LEGACY_OFFSET + q_signed;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // Hold until the output register is free
                    if (slot_free) begin
                        r_out_temp   <= r_temp;
                        r_out_ok     <= (r_status == stdec_pkg::ST_OK);
                        r_out_status <= r_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.temperature = r_out_temp;
    assign o_out.valid_res   = r_out_ok;
    assign o_out.status      = r_out_status;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for scratchpad_temperature_decode
// Drives scratchpad frames byte by byte over the input channel and predicts
// every reading (CRC-8, length, link and all-zero checks, plain and legacy
// temperature formulas). Readings are compared field by field in order.
// A short table of directed frames runs first, then random frames across
// several family code settings and idling patterns on both channels.
// ----------------------------------------------------------------------------
module tb;

    localparam int          SETTLE_CYCLES   = 40;
    localparam int          QUIET_LIMIT     = 3000;
    localparam int          PHASES          = 8;
    localparam int          ITEMS_PER_PHASE = 160;
    localparam int          MAX_FRAME       = 20;
    localparam logic [15:0] LEGACY_MASK     = 16'hFFF0;

    // One reading as it leaves the block
    typedef struct packed {
        logic signed [15:0] temp;
        logic               ok;
        stdec_pkg::t_status st;
    } t_reading;

    // One directed frame; byte 0 sits in payload[7:0]
    typedef struct packed {
        logic [4:0]  nbytes;
        logic [71:0] payload;
        logic        fault;
        logic        seal;
        logic        spoil;
        logic        typed;
        t_reading    want;
    } t_frame_row;

    typedef enum {PACE_FREE, PACE_SRC, PACE_SNK, PACE_BOTH} t_pace;

    localparam t_frame_row DIRECTED [4] = '{
        // one byte, link fault
        '{5'd1, 72'hFF, 1'b1, 1'b0, 1'b0, 1'b1,
          '{stdec_pkg::DISC_TEMP, 1'b0, stdec_pkg::ST_LINK}},
        // nine zero bytes
        '{5'd9, 72'h0, 1'b0, 1'b0, 1'b0, 1'b1,
          '{stdec_pkg::DISC_TEMP, 1'b0, stdec_pkg::ST_ZERO}},
        // all ones with a good check byte, reset family code
        '{5'd9, {9{8'hFF}}, 1'b0, 1'b1, 1'b0, 1'b0,
          '{16'sd0, 1'b0, stdec_pkg::ST_OK}},
        // check byte off by one bit
        '{5'd9, 72'h0100, 1'b0, 1'b1, 1'b1, 1'b1,
          '{stdec_pkg::DISC_TEMP, 1'b0, stdec_pkg::ST_CRC}}
    };

    localparam logic [7:0] PHASE_FAMILY [PHASES] = '{
        stdec_pkg::LEGACY_FAMILY, 8'hFF, 8'h00, stdec_pkg::LEGACY_FAMILY,
        stdec_pkg::FAMILY_RESET, stdec_pkg::LEGACY_FAMILY, stdec_pkg::LEGACY_FAMILY, 8'h00
    };

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    stdec_in_if  in_if ();
    stdec_out_if out_if ();

    scratchpad_temperature_decode DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // Predicted block state
    logic [3:0] frame_pos;
    logic [7:0] crc_run;
    logic       seen_nonzero;
    logic       seen_fault;
    logic [7:0] held_lsb;
    logic [7:0] held_msb;
    logic [7:0] held_remain;
    logic [7:0] held_per;
    logic [7:0] family;

    t_reading   readings_due [$];
    logic [7:0] frame_buf [0:MAX_FRAME-1];
    logic       use_typed = 1'b0;
    t_reading   typed_want;
    int         items_sent = 0;
    int         mismatches = 0;
    int         quiet_cycles = 0;
    int         gap_pct = 0;
    int         stall_pct = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Reflected CRC-8, one byte LSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] v;
        v = c;
        for (int i = 0; i < 8; i++) begin
            if (v[0] ^ b[i]) v = (v >> 1) ^ stdec_pkg::CRC_POLY;
            else v = v >> 1;
        end
        return v;
    endfunction

    // Fold one accepted byte into the predicted state; give a reading on the last byte
    task automatic absorb_byte(input logic [7:0] b, input logic last, input logic fault,
                               output logic fin, output t_reading r);
        logic [15:0]        t;
        int                 num;
        int                 quo;
        int                 acc;
        stdec_pkg::t_status st;
        case (frame_pos)
            stdec_pkg::IDX_TEMP_LSB:  held_lsb = b;
            stdec_pkg::IDX_TEMP_MSB:  held_msb = b;
            stdec_pkg::IDX_COUNT_REM: held_remain = b;
            stdec_pkg::IDX_COUNT_PER: held_per = b;
            default: ;
        endcase
        crc_run = crc8_byte(crc_run, b);
        if (b != 8'h00) seen_nonzero = 1'b1;
        if (fault) seen_fault = 1'b1;
        if (frame_pos != stdec_pkg::INDEX_MAX) frame_pos = frame_pos + 4'd1;
        fin = last;
        r = '0;
        if (last) begin
            if (seen_fault || frame_pos != stdec_pkg::FRAME_BYTES) st = stdec_pkg::ST_LINK;
            else if (!seen_nonzero) st = stdec_pkg::ST_ZERO;
            else if (crc_run != 8'h00) st = stdec_pkg::ST_CRC;
            else st = stdec_pkg::ST_OK;
            if (st != stdec_pkg::ST_OK) begin
                r.temp = stdec_pkg::DISC_TEMP;
            end else begin
                t = {held_msb[4:0], held_lsb, 3'b000};
                if (family == stdec_pkg::LEGACY_FAMILY && held_per != 8'h00) begin
                    // count fraction truncates toward zero, then wrap to 16 bits
                    num = (int'(held_per) - int'(held_remain)) * 128;
                    quo = num / int'(held_per);
                    acc = int'(t & LEGACY_MASK) * 8 - int'(stdec_pkg::LEGACY_OFFSET) + quo;
                    r.temp = acc[15:0];
                end else begin
                    r.temp = t;
                end
            end
            r.ok = (st == stdec_pkg::ST_OK);
            r.st = st;
            frame_pos = '0;
            crc_run = '0;
            seen_nonzero = 1'b0;
            seen_fault = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch: %s got %h want %h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // Present one byte from a falling edge, hold until the beat is taken
    task automatic send_byte(input logic [7:0] b, input logic last, input logic fault);
        logic     fin;
        t_reading r;
        while ($urandom_range(0, 99) < gap_pct) begin
            in_if.valid <= 1'b0;
            @(negedge clk);
        end
        in_if.valid      <= 1'b1;
        in_if.data_byte  <= b;
        in_if.last_byte  <= last;
        in_if.link_fault <= fault;
        do @(posedge clk); while (in_if.ready !== 1'b1);
        absorb_byte(b, last, fault, fin, r);
        if (fin) readings_due.push_back(use_typed ? typed_want : r);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame(input int nb, input int fault_at);
        for (int i = 0; i < nb; i++)
            send_byte(frame_buf[i], i == nb - 1, i == fault_at);
    endtask

    // Make the last byte the CRC of the ones before it
    task automatic seal_frame(input int nb);
        logic [7:0] c;
        c = '0;
        for (int i = 0; i < nb - 1; i++) c = crc8_byte(c, frame_buf[i]);
        frame_buf[nb-1] = c;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly well-formed scratchpads, the rest zero, corrupted, faulted or mis-sized
    task automatic build_random_frame(output int nb, output int fault_at);
        int         kind;
        logic [7:0] per;
        kind = $urandom_range(0, 99);
        nb = stdec_pkg::FRAME_BYTES_N;
        fault_at = -1;
        for (int i = 0; i < MAX_FRAME; i++) frame_buf[i] = pick_byte();
        if (kind < 86 && kind >= 72 && kind < 78) begin
            for (int i = 0; i < MAX_FRAME; i++) frame_buf[i] = 8'h00;
        end else if (kind < 92) begin
            case ($urandom_range(0, 5))
                0: per = 8'h00;
                1: per = 8'h01;
                2: per = 8'h10;
                3: per = 8'hFF;
                default: per = 8'($urandom_range(0, 255));
            endcase
            frame_buf[stdec_pkg::IDX_COUNT_PER] = per;
            frame_buf[stdec_pkg::IDX_COUNT_REM] = ($urandom_range(0, 3) == 0) ?
                8'($urandom_range(0, 255)) : 8'($urandom_range(0, per));
            seal_frame(nb);
            // flip one bit anywhere in the frame
            if (kind >= 78 && kind < 86)
                frame_buf[$urandom_range(0, 8)][$urandom_range(0, 7)] ^= 1'b1;
            if (kind >= 86) fault_at = $urandom_range(0, 8);
        end else begin
            nb = $urandom_range(1, MAX_FRAME);
            if (nb == stdec_pkg::FRAME_BYTES_N) nb = stdec_pkg::FRAME_BYTES_N + 1;
            if ($urandom_range(0, 1) == 0) seal_frame(nb);
            if ($urandom_range(0, 3) == 0) fault_at = $urandom_range(0, nb - 1);
        end
    endtask

    // Stop sending, wait for every reading, then let the block settle
    task automatic drain();
        in_if.valid <= 1'b0;
        while (readings_due.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_family(input logic [7:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        family = v;
    endtask

    task automatic set_pacing(input t_pace p);
        case (p)
            PACE_FREE: begin gap_pct = 0;  stall_pct = 0;  end
            PACE_SRC:  begin gap_pct = 69; stall_pct = 0;  end
            PACE_SNK:  begin gap_pct = 0;  stall_pct = 69; end
            default:   begin gap_pct = 24; stall_pct = 24; end
        endcase
    endtask

    // Receiver: redraw ready at every falling edge
    always @(negedge clk) out_if.ready <= ($urandom_range(0, 99) >= stall_pct);

    // Check each reading beat against the oldest prediction
    always @(posedge clk) begin : check_readings
        t_reading due;
        if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (readings_due.size() == 0) begin
                report_mismatch("unexpected reading", out_if.temperature, 16'h0);
            end else begin
                due = readings_due.pop_front();
                if (out_if.temperature !== due.temp)
                    report_mismatch("temperature", out_if.temperature, due.temp);
                if (out_if.valid_res !== due.ok)
                    report_mismatch("valid_res", 16'(out_if.valid_res), 16'(due.ok));
                if (out_if.status !== due.st)
                    report_mismatch("status", 16'(out_if.status), 16'(due.st));
            end
        end
    end

    // Watchdog: give up after a long stretch with no beat on either channel
    always @(posedge clk) begin
        if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
            (out_if.valid === 1'b1 && out_if.ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    initial begin
        int         nb;
        int         fault_at;
        int         phase_start;
        logic [7:0] fam;
        t_frame_row row;

        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = 8'h00;
        in_if.valid      = 1'b0;
        in_if.data_byte  = 8'h00;
        in_if.last_byte  = 1'b0;
        in_if.link_fault = 1'b0;
        family           = stdec_pkg::FAMILY_RESET;
        frame_pos        = '0;
        crc_run          = '0;
        seen_nonzero     = 1'b0;
        seen_fault       = 1'b0;
        held_lsb         = '0;
        held_msb         = '0;
        held_remain      = '0;
        held_per         = '0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed frames
        for (int k = 0; k < $size(DIRECTED); k++) begin
            row = DIRECTED[k];
            for (int i = 0; i < stdec_pkg::FRAME_BYTES_N; i++)
                frame_buf[i] = row.payload[8*i +: 8];
            if (row.seal) seal_frame(row.nbytes);
            if (row.spoil) frame_buf[row.nbytes-1][0] ^= 1'b1;
            use_typed  = row.typed;
            typed_want = row.want;
            send_frame(row.nbytes, row.fault ? 0 : -1);
        end
        use_typed = 1'b0;
        drain();

        // Random frames, one family code and idling pattern per phase
        for (int ph = 0; ph < PHASES; ph++) begin
            set_pacing(t_pace'(ph % 4));
            fam = (ph == PHASES - 1) ? 8'($urandom_range(0, 255)) : PHASE_FAMILY[ph];
            write_family(fam);
            phase_start = items_sent;
            while (items_sent - phase_start < ITEMS_PER_PHASE) begin
                build_random_frame(nb, fault_at);
                send_frame(nb, fault_at);
                if ($urandom_range(0, 19) == 0) drain();
            end
            drain();
        end

        if (mismatches == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// ===== scratchpad_temperature_decode.f =====
rtl/stdec_pkg.sv
rtl/stdec_if.sv
rtl/stdec_crc.sv
rtl/stdec_div.sv
rtl/scratchpad_temperature_decode.sv
test/tb.sv
